[rtl/core/npt_pkg.sv]
// shared types, opcodes and default sizes of the named point table
`default_nettype none

package npt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam int DEFAULT_KEY_BITS    = 64;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_DEL_KEY   = 3'd1;
  localparam logic [2:0] OP_DEL_SLOT  = 3'd2;
  localparam logic [2:0] OP_LOOKUP    = 3'd3;
  localparam logic [2:0] OP_READ_SLOT = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [63:0]        key;
    logic [4:0]         slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic [4:0]         found_slot;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [5:0]         entry_count;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/core/npt_stream.sv]
// valid/ready stream channel carrying one payload per beat
`default_nettype none

interface npt_stream #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/named_point_table_swap_delete.sv]
// Keyed point table with swap-on-delete. Up to TABLE_DEPTH entries of
// {key, x, y} live packed in slots 0..count-1 of one synchronous RAM. One
// command beat is taken at a time on cmd and answered by exactly one beat on
// rsp. A key search (add, delete by key, lookup) walks the RAM one entry per
// cycle through its single read port; a delete that leaves a hole below the
// last entry then reads the last entry and writes it into the hole. Read by
// slot and a delete by slot with a move issue a RAM read in S_RDISS and use
// the data in S_RDUSE; a delete of the last slot, an add to a full table and
// an unused opcode go straight to S_DONE. The rsp register is separate, so a
// new command is taken while the previous answer still waits on rsp; the new
// answer is held until that beat is taken. No clearing pass is needed after
// reset: only slots below count are ever read.
`default_nettype none

module named_point_table_swap_delete #(
  parameter int TABLE_DEPTH = npt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int KEY_BITS    = npt_pkg::DEFAULT_KEY_BITS
) (
  input wire logic clk,
  input wire logic rst,
  npt_stream.sink   cmd,
  npt_stream.source rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > 5) ? CW : 5;   // width for slot vs count compare
  localparam int DW = KEY_BITS + 64;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RDISS = 3'd2;
  localparam logic [2:0] S_RDUSE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  logic [2:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         x_q;
  logic [31:0]         y_q;
  logic [AW-1:0]       slot_q;     // read target for slot read / swap source
  logic [AW-1:0]       where;      // slot reported in the answer
  logic [CW-1:0]       count;
  logic [CW-1:0]       scan_idx;
  logic                pend;       // a scan read was issued last cycle
  logic [AW-1:0]       pend_idx;
  logic                res_ok;
  logic [31:0]         res_x;
  logic [31:0]         res_y;
  logic                rsp_valid;
  npt_pkg::rsp_t       rsp_q;

  // ram ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_x;
  logic [31:0]         rd_y;
  logic                hit;
  logic                scan_more;
  logic                slot_ok;
  logic [CW-1:0]       last;

  npt_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key = rd_data[DW-1:64];
  assign rd_x   = rd_data[63:32];
  assign rd_y   = rd_data[31:0];

  // the compare works on data read in the previous cycle
  assign hit       = pend && (rd_key == key_q);
  assign scan_more = (scan_idx < count);
  assign slot_ok   = (SW'(cmd.data.slot) < SW'(count));
  assign last      = count - CW'(1);

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_q;
    wr_en   = 1'b0;
    wr_addr = where;
    wr_data = rd_data;
    case (state)
      S_SCAN: begin
        rd_addr = scan_idx[AW-1:0];
        rd_en   = !hit && scan_more;
        // key not present: an add appends at the end (fullness checked on accept)
        if (!hit && !scan_more && (op_q == npt_pkg::OP_ADD)) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_data = {key_q, x_q, y_q};
        end
      end
      S_RDISS: begin
        rd_en = 1'b1;
      end
      S_RDUSE: begin
        // swap: last entry moves into the freed slot
        wr_en = (op_q != npt_pkg::OP_READ_SLOT);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // beat taken and no new answer loading this cycle
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_q     <= cmd.data.opcode;
            key_q    <= cmd.data.key[KEY_BITS-1:0];
            x_q      <= cmd.data.point_x;
            y_q      <= cmd.data.point_y;
            res_x    <= '0;
            res_y    <= '0;
            scan_idx <= '0;
            pend     <= 1'b0;
            case (cmd.data.opcode)
              npt_pkg::OP_ADD: begin
                where  <= '0;
                res_ok <= 1'b0;
                state  <= (count != CW'(TABLE_DEPTH)) ? S_SCAN : S_DONE;
              end
              npt_pkg::OP_DEL_KEY, npt_pkg::OP_LOOKUP: begin
                where  <= '0;
                res_ok <= 1'b0;
                state  <= S_SCAN;
              end
              npt_pkg::OP_DEL_SLOT: begin
                if (slot_ok) begin
                  where <= AW'(cmd.data.slot);
                  if (SW'(cmd.data.slot) == SW'(last)) begin
                    // dropping the last entry needs no move
                    count  <= last;
                    res_ok <= 1'b1;
                    state  <= S_DONE;
                  end else begin
                    slot_q <= last[AW-1:0];
                    res_ok <= 1'b0;
                    state  <= S_RDISS;
                  end
                end else begin
                  where  <= '0;
                  res_ok <= 1'b0;
                  state  <= S_DONE;
                end
              end
              npt_pkg::OP_READ_SLOT: begin
                res_ok <= 1'b0;
                if (slot_ok) begin
                  where  <= AW'(cmd.data.slot);
                  slot_q <= AW'(cmd.data.slot);
                  state  <= S_RDISS;
                end else begin
                  where <= '0;
                  state <= S_DONE;
                end
              end
              default: begin
                where  <= '0;
                res_ok <= 1'b0;
                state  <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (hit) begin
            pend <= 1'b0;
            case (op_q)
              npt_pkg::OP_LOOKUP: begin
                res_ok <= 1'b1;
                res_x  <= rd_x;
                res_y  <= rd_y;
                where  <= pend_idx;
                state  <= S_DONE;
              end
              npt_pkg::OP_DEL_KEY: begin
                where <= pend_idx;
                if (pend_idx == last[AW-1:0]) begin
                  count  <= last;
                  res_ok <= 1'b1;
                  state  <= S_DONE;
                end else begin
                  slot_q <= last[AW-1:0];
                  state  <= S_RDISS;
                end
              end
              default: begin
                // duplicate key on add
                state <= S_DONE;
              end
            endcase
          end else if (scan_more) begin
            scan_idx <= scan_idx + CW'(1);
            pend     <= 1'b1;
            pend_idx <= scan_idx[AW-1:0];
          end else begin
            pend  <= 1'b0;
            state <= S_DONE;
            if (op_q == npt_pkg::OP_ADD) begin
              count  <= count + CW'(1);
              where  <= count[AW-1:0];
              res_ok <= 1'b1;
            end
          end
        end

        S_RDISS: begin
          state <= S_RDUSE;
        end

        S_RDUSE: begin
          res_ok <= 1'b1;
          if (op_q == npt_pkg::OP_READ_SLOT) begin
            res_x <= rd_x;
            res_y <= rd_y;
          end else begin
            count <= last;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_q.ok          <= res_ok;
            rsp_q.found_slot  <= res_ok ? 5'(where) : 5'd0;
            rsp_q.out_x       <= res_x;
            rsp_q.out_y       <= res_y;
            rsp_q.entry_count <= 6'(count);
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/npt_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module npt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[bench/npt_table_checker.sv]
// scoreboard for the named point table: predicts each answer and checks the rsp beats
`timescale 1ns / 100ps

module npt_table_checker #(
  parameter int TABLE_DEPTH = npt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  npt_pkg::cmd_t cmd_data,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  npt_pkg::rsp_t rsp_data,
  output int            fail_count,
  output int            pending_count
);

  // shadow copy of the table contents
  logic [63:0] key_tbl [TABLE_DEPTH];
  logic [31:0] x_tbl   [TABLE_DEPTH];
  logic [31:0] y_tbl   [TABLE_DEPTH];
  int          stored;

  npt_pkg::rsp_t answer_q [$];
  npt_pkg::rsp_t want;
  int            answer_idx;

  task automatic report_mismatch(input string msg);
    $display("answer %0d: %s", answer_idx, msg);
    fail_count++;
  endtask

  // swap the last entry into the hole and shrink
  function automatic void drop_slot(input int s);
    int last;
    last       = stored - 1;
    key_tbl[s] = key_tbl[last];
    x_tbl[s]   = x_tbl[last];
    y_tbl[s]   = y_tbl[last];
    stored     = last;
  endfunction

  function automatic npt_pkg::rsp_t predict_answer(input npt_pkg::cmd_t c);
    npt_pkg::rsp_t r;
    int            hit;
    r   = '0;
    hit = -1;
    for (int i = 0; i < stored; i++) begin
      if (hit < 0 && key_tbl[i] == c.key) hit = i;
    end
    case (c.opcode)
      npt_pkg::OP_ADD: begin
        if (stored < TABLE_DEPTH && hit < 0) begin
          key_tbl[stored] = c.key;
          x_tbl[stored]   = c.point_x;
          y_tbl[stored]   = c.point_y;
          r.ok            = 1'b1;
          r.found_slot    = stored[4:0];
          stored++;
        end
      end
      npt_pkg::OP_DEL_KEY: begin
        if (hit >= 0) begin
          drop_slot(hit);
          r.ok         = 1'b1;
          r.found_slot = hit[4:0];
        end
      end
      npt_pkg::OP_DEL_SLOT: begin
        if (int'(c.slot) < stored) begin
          drop_slot(int'(c.slot));
          r.ok         = 1'b1;
          r.found_slot = c.slot;
        end
      end
      npt_pkg::OP_LOOKUP: begin
        if (hit >= 0) begin
          r.ok         = 1'b1;
          r.found_slot = hit[4:0];
          r.out_x      = x_tbl[hit];
          r.out_y      = y_tbl[hit];
        end
      end
      npt_pkg::OP_READ_SLOT: begin
        if (int'(c.slot) < stored) begin
          r.ok         = 1'b1;
          r.found_slot = c.slot;
          r.out_x      = x_tbl[c.slot];
          r.out_y      = y_tbl[c.slot];
        end
      end
      default: ;
    endcase
    r.entry_count = stored[5:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored        = 0;
      answer_idx    = 0;
      fail_count    = 0;
      pending_count = 0;
      answer_q.delete();
    end else begin
      // answer beats first: one taken this edge belongs to an older command
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("answer with no command outstanding");
        end else begin
          want = answer_q.pop_front();
          if (rsp_data.ok !== want.ok)
            report_mismatch($sformatf("ok got %0b want %0b", rsp_data.ok, want.ok));
          if (rsp_data.found_slot !== want.found_slot)
            report_mismatch($sformatf("found_slot got %0d want %0d",
                                      rsp_data.found_slot, want.found_slot));
          if (rsp_data.out_x !== want.out_x)
            report_mismatch($sformatf("out_x got %0d want %0d", rsp_data.out_x, want.out_x));
          if (rsp_data.out_y !== want.out_y)
            report_mismatch($sformatf("out_y got %0d want %0d", rsp_data.out_y, want.out_y));
          if (rsp_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      rsp_data.entry_count, want.entry_count));
        end
        answer_idx++;
      end
      if (cmd_valid && cmd_ready) answer_q.push_back(predict_answer(cmd_data));
      pending_count = answer_q.size();
    end
  end

endmodule

[bench/tb.sv]
// top of the named point table bench: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_ITEMS = 1600;
  localparam int POOL_SIZE    = 48;     // more keys than slots so the table fills
  localparam int OPCODE_SPAN  = 8;      // all codes of the 3-bit opcode field
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off in the quiet phase
  localparam int DRAIN_CYCLES = 60;     // extra wait once every answer is back
  localparam int CYCLE_LIMIT  = 400000;

  // idling phases
  localparam int PHASE_SEND_SPARSE = 0;  // sender rarely idles, receiver often
  localparam int PHASE_RECV_SPARSE = 1;  // the other way round
  localparam int PHASE_QUIET       = 2;  // no random idling, one long receiver hold-off

  logic clk;
  logic rst;

  npt_stream #(.payload_t(npt_pkg::cmd_t)) cmd_ch ();
  npt_stream #(.payload_t(npt_pkg::rsp_t)) rsp_ch ();

  int fail_count;
  int pending_count;
  int cycle_count;

  int idle_phase;
  int send_idle_pct;
  int recv_idle_pct;

  logic [63:0] key_pool [POOL_SIZE];

  named_point_table_swap_delete uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  npt_table_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_ch.valid),
    .cmd_ready     (cmd_ch.ready),
    .cmd_data      (cmd_ch.data),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_data      (rsp_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop in case the block hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic npt_pkg::cmd_t make_cmd(input logic [2:0] op, input logic [63:0] k,
                                             input logic [4:0] s, input logic [31:0] x,
                                             input logic [31:0] y);
    npt_pkg::cmd_t c;
    c.opcode  = op;
    c.key     = k;
    c.slot    = s;
    c.point_x = x;
    c.point_y = y;
    return c;
  endfunction

  // mostly random coordinates, now and then an extreme
  function automatic logic [31:0] random_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return 32'h8000_0000;
    if (roll < 8) return 32'h7fff_ffff;
    if (roll < 10) return 32'h0;
    return $urandom;
  endfunction

  // offer one command beat, idling first at the current sender rate;
  // valid stays high into the next call so back-to-back beats need no dip
  task automatic send_cmd(input npt_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // receiver: random stalls per phase, plus one long hold-off at the start of
  // the quiet phase so the answer register fills and the block stalls cmd
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_phase == PHASE_QUIET && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // command stimulus and verdict
  initial begin
    logic [63:0] key_a;
    logic [2:0]  op;
    logic [63:0] k;
    bit          filling;
    int          episode_left;
    int          roll;

    rst           = 1'b1;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    idle_phase    = PHASE_SEND_SPARSE;
    send_idle_pct = 6;
    recv_idle_pct = 48;

    // key pool: the two extreme keys plus random ones
    key_pool[0] = 64'h0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_a = key_pool[2];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table misses
    send_cmd(make_cmd(npt_pkg::OP_LOOKUP,    key_pool[0], 5'd0, 32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_DEL_KEY,   key_pool[0], 5'd0, 32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_DEL_SLOT,  key_pool[0], 5'd0, 32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_READ_SLOT, key_pool[0], 5'd0, 32'h0, 32'h0));
    // unused opcodes with random fields
    for (int u = npt_pkg::OP_READ_SLOT + 1; u < OPCODE_SPAN; u++)
      send_cmd(make_cmd(u[2:0], {$urandom, $urandom}, 5'($urandom), $urandom, $urandom));
    // extreme keys and points, then a duplicate add
    send_cmd(make_cmd(npt_pkg::OP_ADD, key_pool[0], 5'd31, 32'h8000_0000, 32'h7fff_ffff));
    send_cmd(make_cmd(npt_pkg::OP_ADD, key_pool[1], 5'd0,  32'h7fff_ffff, 32'h8000_0000));
    send_cmd(make_cmd(npt_pkg::OP_ADD, key_pool[0], 5'd0,  32'h1234_5678, 32'h1));
    send_cmd(make_cmd(npt_pkg::OP_ADD, key_a,       5'd0,  32'h0,         32'hffff_ffff));
    send_cmd(make_cmd(npt_pkg::OP_LOOKUP,    key_pool[1], 5'd0,  32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_READ_SLOT, key_pool[0], 5'd1,  32'h0, 32'h0));
    // slot out of range: far above and exactly at the count
    send_cmd(make_cmd(npt_pkg::OP_READ_SLOT, key_pool[0], 5'd31, 32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_READ_SLOT, key_pool[0], 5'd3,  32'h0, 32'h0));
    // delete slot 0: last entry swaps into the hole
    send_cmd(make_cmd(npt_pkg::OP_DEL_SLOT,  key_pool[0], 5'd0,  32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_LOOKUP,    key_pool[0], 5'd0,  32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_READ_SLOT, key_pool[0], 5'd0,  32'h0, 32'h0));
    // deleting the last slot, by slot and then by key
    send_cmd(make_cmd(npt_pkg::OP_DEL_SLOT,  key_pool[0], 5'd1,  32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_DEL_KEY,   key_a,       5'd0,  32'h0, 32'h0));
    send_cmd(make_cmd(npt_pkg::OP_DEL_KEY,   key_a,       5'd0,  32'h0, 32'h0));
    // a key one bit away from a stored one must miss
    send_cmd(make_cmd(npt_pkg::OP_ADD, key_a, 5'd0, 32'h5555_5555, 32'haaaa_aaaa));
    send_cmd(make_cmd(npt_pkg::OP_DEL_KEY, key_a ^ (64'h1 << $urandom_range(63)), 5'd0,
                      32'h0, 32'h0));

    // random part in episodes that either fill the table or drain it
    filling      = 1'b1;
    episode_left = $urandom_range(160, 40);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        idle_phase    = PHASE_RECV_SPARSE;
        send_idle_pct = 48;
        recv_idle_pct = 6;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        idle_phase    = PHASE_QUIET;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (episode_left == 0) begin
        filling      = 1'($urandom_range(1));
        episode_left = $urandom_range(160, 40);
      end
      episode_left--;

      roll = $urandom_range(99);
      if (filling) begin
        if      (roll < 60) op = npt_pkg::OP_ADD;
        else if (roll < 68) op = npt_pkg::OP_DEL_KEY;
        else if (roll < 75) op = npt_pkg::OP_DEL_SLOT;
        else if (roll < 87) op = npt_pkg::OP_LOOKUP;
        else if (roll < 97) op = npt_pkg::OP_READ_SLOT;
        else op = 3'($urandom_range(OPCODE_SPAN - 1, npt_pkg::OP_READ_SLOT + 1));
      end else begin
        if      (roll < 15) op = npt_pkg::OP_ADD;
        else if (roll < 45) op = npt_pkg::OP_DEL_KEY;
        else if (roll < 70) op = npt_pkg::OP_DEL_SLOT;
        else if (roll < 85) op = npt_pkg::OP_LOOKUP;
        else if (roll < 97) op = npt_pkg::OP_READ_SLOT;
        else op = 3'($urandom_range(OPCODE_SPAN - 1, npt_pkg::OP_READ_SLOT + 1));
      end

      // mostly pool keys so hits and duplicates are common, some noise
      if ($urandom_range(99) < 90) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else                         k = {$urandom, $urandom};

      send_cmd(make_cmd(op, k, 5'($urandom), random_coord(), random_coord()));
    end
    cmd_ch.valid <= 1'b0;

    // let every answer come back, then a little more
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/npt_pkg.sv
rtl/core/npt_stream.sv
rtl/core/npt_ram.sv
rtl/core/named_point_table_swap_delete.sv
bench/npt_table_checker.sv
bench/tb.sv
